>>> design/uyv_pkg.sv
// Package for the UYVY 4:2:2 to RGB888 converter.
// Holds the fixed-point matrix coefficients, sample types and stage structs.
// Depends on nothing; used by every module of the block.
package uyv_pkg;

	localparam int FRAC_BITS = 14;
	localparam int TERM_W    = 23;
	localparam int ACC_W     = 25;

	typedef logic        [7:0]        byte_t;
	typedef logic signed [7:0]        chroma_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	localparam term_t COEF_R_U = -23'sd15;
	localparam term_t COEF_R_V = 23'sd22965;
	localparam term_t COEF_G_U = -23'sd5631;
	localparam term_t COEF_G_V = -23'sd11701;
	localparam term_t COEF_B_U = 23'sd29035;
	localparam term_t COEF_B_V = 23'sd16;

	typedef struct packed {
		term_t r;
		term_t g;
		term_t b;
	} chroma_terms_t;

	typedef struct packed {
		byte_t r;
		byte_t g;
		byte_t b;
	} rgb_t;

endpackage

>>> design/uyv_chroma.sv
// Shared chroma unit: removes the chroma offset and forms the chroma part of each channel.
// The result is registered once and feeds both pixel lanes.
// Depends on uyv_pkg.
module uyv_chroma (
	input  logic                  clk,
	input  uyv_pkg::byte_t        chroma_u,
	input  uyv_pkg::byte_t        chroma_v,
	output uyv_pkg::chroma_terms_t terms_s1
);
	import uyv_pkg::*;

	chroma_t       u_off;
	chroma_t       v_off;
	term_t         u_ext;
	term_t         v_ext;
	chroma_terms_t terms;

	// Subtracting 128 from an unsigned byte is the same as flipping its top bit.
	assign u_off = chroma_t'({~chroma_u[7], chroma_u[6:0]});
	assign v_off = chroma_t'({~chroma_v[7], chroma_v[6:0]});
	assign u_ext = term_t'(u_off);
	assign v_ext = term_t'(v_off);

	always_comb begin
		terms.r = term_t'(COEF_R_U * u_ext) + term_t'(COEF_R_V * v_ext);
		terms.g = term_t'(COEF_G_U * u_ext) + term_t'(COEF_G_V * v_ext);
		terms.b = term_t'(COEF_B_U * u_ext) + term_t'(COEF_B_V * v_ext);
	end

	always_ff @(posedge clk) begin
		terms_s1 <= terms;
	end

endmodule

>>> design/uyv_lane.sv
// One pixel lane: adds the scaled luma to the shared chroma terms, then truncates and saturates.
// The saturated pixel is registered at the lane output.
// Depends on uyv_pkg.
module uyv_lane (
	input  logic                   clk,
	input  uyv_pkg::byte_t         luma_s1,
	input  uyv_pkg::chroma_terms_t terms_s1,
	output uyv_pkg::rgb_t          pixel_s2
);
	import uyv_pkg::*;

	acc_t luma_scaled;
	rgb_t pixel;

	function automatic byte_t clamp_channel(acc_t acc);
		byte_t res;
		if (acc[ACC_W-1]) begin
			res = 8'd0;
		end else if (|acc[ACC_W-2:FRAC_BITS+8]) begin
			res = 8'd255;
		end else begin
			res = acc[FRAC_BITS+7:FRAC_BITS];
		end
		return res;
	endfunction

	assign luma_scaled = acc_t'({1'b0, luma_s1, {FRAC_BITS{1'b0}}});

	always_comb begin
		pixel.r = clamp_channel(luma_scaled + acc_t'(terms_s1.r));
		pixel.g = clamp_channel(luma_scaled + acc_t'(terms_s1.g));
		pixel.b = clamp_channel(luma_scaled + acc_t'(terms_s1.b));
	end

	always_ff @(posedge clk) begin
		pixel_s2 <= pixel;
	end

endmodule

>>> design/uyvy422_to_rgb888.sv
// Top level of the UYVY 4:2:2 to RGB888 converter.
// Instantiates the shared chroma unit and two pixel lanes and merges their results.
// Depends on uyv_pkg, uyv_chroma and uyv_lane.

// The converter takes one UYVY item in every clock cycle and never raises busy. Each item
// passes the following stages in order, and done is high for a single cycle as its result comes out: one stage
// for the chroma products, one for the luma add and saturation in each of the two pixel
// lanes, and one output register that merges both pixels with the frame end mark. The
// receiver cannot stall the block, so it must take every result in the cycle it appears.
module uyvy422_to_rgb888 (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  uyv_pkg::byte_t chroma_u,
	input  uyv_pkg::byte_t luma_first,
	input  uyv_pkg::byte_t chroma_v,
	input  uyv_pkg::byte_t luma_second,
	input  logic           frame_end_in,
	output logic           done,
	output uyv_pkg::byte_t red_first,
	output uyv_pkg::byte_t green_first,
	output uyv_pkg::byte_t blue_first,
	output uyv_pkg::byte_t red_second,
	output uyv_pkg::byte_t green_second,
	output uyv_pkg::byte_t blue_second,
	output logic           frame_end_out
);
	import uyv_pkg::*;

	logic          vld_s1;
	logic          vld_s2;
	logic          done_q;
	byte_t         luma_first_s1;
	byte_t         luma_second_s1;
	logic          frame_end_s1;
	logic          frame_end_s2;
	chroma_terms_t terms_s1;
	rgb_t          pix_first_s2;
	rgb_t          pix_second_s2;
	rgb_t          pix_first_q;
	rgb_t          pix_second_q;
	logic          frame_end_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		luma_first_s1  <= luma_first;
		luma_second_s1 <= luma_second;
		frame_end_s1   <= frame_end_in;
		frame_end_s2   <= frame_end_s1;
	end

	uyv_chroma u_chroma (
		.clk      (clk),
		.chroma_u (chroma_u),
		.chroma_v (chroma_v),
		.terms_s1 (terms_s1)
	);

	uyv_lane u_lane_first (
		.clk      (clk),
		.luma_s1  (luma_first_s1),
		.terms_s1 (terms_s1),
		.pixel_s2 (pix_first_s2)
	);

	uyv_lane u_lane_second (
		.clk      (clk),
		.luma_s1  (luma_second_s1),
		.terms_s1 (terms_s1),
		.pixel_s2 (pix_second_s2)
	);

	always_ff @(posedge clk) begin
		pix_first_q  <= pix_first_s2;
		pix_second_q <= pix_second_s2;
		frame_end_q  <= frame_end_s2;
	end

	assign done          = done_q;
	assign red_first     = pix_first_q.r;
	assign green_first   = pix_first_q.g;
	assign blue_first    = pix_first_q.b;
	assign red_second    = pix_second_q.r;
	assign green_second  = pix_second_q.g;
	assign blue_second   = pix_second_q.b;
	assign frame_end_out = frame_end_q;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("Result strobe without an item taken three cycles before.");

	a_frame_end_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (frame_end_out == $past(frame_end_in, 3)))
		else $error("Frame end mark out of step with its item.");

	a_vld_chain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |=> done)
		else $error("Item lost between the lanes and the output register.");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UYVY 4:2:2 to RGB888 converter, top module tb_top.
// A scoreboard class predicts both RGB pixels of each accepted item and checks every result.
// Depends on uyv_pkg and uyvy422_to_rgb888.
module tb_top;

	import uyv_pkg::byte_t;

	localparam int RANDOM_ITEMS = 650;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		byte_t red_first;
		byte_t green_first;
		byte_t blue_first;
		byte_t red_second;
		byte_t green_second;
		byte_t blue_second;
		logic  frame_end;
	} pixel_pair_t;

	class rgb_scoreboard;
		localparam int CHROMA_BIAS = 128;
		localparam int FRACTION    = 14;
		localparam int RED_U       = -15;
		localparam int RED_V       = 22965;
		localparam int GREEN_U     = -5631;
		localparam int GREEN_V     = -11701;
		localparam int BLUE_U      = 29035;
		localparam int BLUE_V      = 16;

		pixel_pair_t expected_pairs[$];
		int unsigned fault_count;

		function byte_t convert_channel(int luma, int u, int v, int coef_u, int coef_v);
			int sum;
			int whole;
			sum = (luma <<< FRACTION) + coef_u * u + coef_v * v;
			if (sum < 0) begin
				return 8'd0;
			end
			whole = sum >>> FRACTION;
			if (whole > 255) begin
				return 8'd255;
			end
			return byte_t'(whole);
		endfunction

		function void note_pair(byte_t cu, byte_t y1, byte_t cv, byte_t y2, logic fe);
			pixel_pair_t pair;
			int u;
			int v;
			u = int'(cu) - CHROMA_BIAS;
			v = int'(cv) - CHROMA_BIAS;
			pair.red_first    = convert_channel(int'(y1), u, v, RED_U, RED_V);
			pair.green_first  = convert_channel(int'(y1), u, v, GREEN_U, GREEN_V);
			pair.blue_first   = convert_channel(int'(y1), u, v, BLUE_U, BLUE_V);
			pair.red_second   = convert_channel(int'(y2), u, v, RED_U, RED_V);
			pair.green_second = convert_channel(int'(y2), u, v, GREEN_U, GREEN_V);
			pair.blue_second  = convert_channel(int'(y2), u, v, BLUE_U, BLUE_V);
			pair.frame_end    = fe;
			expected_pairs.push_back(pair);
		endfunction

		function void check_pair(pixel_pair_t got);
			pixel_pair_t want;
			if (expected_pairs.size() == 0) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("%0t: result with no item pending: %h", $realtime, got);
				end
				return;
			end
			want = expected_pairs.pop_front();
			if (got.red_first !== want.red_first || got.green_first !== want.green_first ||
				got.blue_first !== want.blue_first || got.red_second !== want.red_second ||
				got.green_second !== want.green_second ||
				got.blue_second !== want.blue_second || got.frame_end !== want.frame_end) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("%0t: expected rgb %0d,%0d,%0d / %0d,%0d,%0d fe %0b", $realtime,
						want.red_first, want.green_first, want.blue_first, want.red_second,
						want.green_second, want.blue_second, want.frame_end);
					$display("%0t: actual   rgb %0d,%0d,%0d / %0d,%0d,%0d fe %0b", $realtime,
						got.red_first, got.green_first, got.blue_first, got.red_second,
						got.green_second, got.blue_second, got.frame_end);
				end
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	byte_t chroma_u;
	byte_t luma_first;
	byte_t chroma_v;
	byte_t luma_second;
	logic  frame_end_in;
	logic  done;
	byte_t red_first;
	byte_t green_first;
	byte_t blue_first;
	byte_t red_second;
	byte_t green_second;
	byte_t blue_second;
	logic  frame_end_out;

	rgb_scoreboard sb = new();
	pixel_pair_t   result_seen;
	int unsigned   idle_cycles;
	int            stream_left;

	uyvy422_to_rgb888 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.chroma_u     (chroma_u),
		.luma_first   (luma_first),
		.chroma_v     (chroma_v),
		.luma_second  (luma_second),
		.frame_end_in (frame_end_in),
		.done         (done),
		.red_first    (red_first),
		.green_first  (green_first),
		.blue_first   (blue_first),
		.red_second   (red_second),
		.green_second (green_second),
		.blue_second  (blue_second),
		.frame_end_out(frame_end_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (start && !busy) begin
			sb.note_pair(chroma_u, luma_first, chroma_v, luma_second, frame_end_in);
		end
		if (done) begin
			result_seen = '{red_first, green_first, blue_first, red_second, green_second,
				blue_second, frame_end_out};
			sb.check_pair(result_seen);
		end
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic byte_t pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_gap();
		int roll;
		if (stream_left > 0) begin
			stream_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			stream_left = $urandom_range(10, 60);
			return 0;
		end else if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_pair(byte_t cu, byte_t y1, byte_t cv, byte_t y2, logic fe, int gap);
		bit taken;
		@(negedge clk);
		start        <= 1'b1;
		chroma_u     <= cu;
		luma_first   <= y1;
		chroma_v     <= cv;
		luma_second  <= y2;
		frame_end_in <= fe;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		if (gap > 0) begin
			@(negedge clk);
			start        <= 1'b0;
			chroma_u     <= byte_t'($urandom_range(0, 255));
			luma_first   <= byte_t'($urandom_range(0, 255));
			chroma_v     <= byte_t'($urandom_range(0, 255));
			luma_second  <= byte_t'($urandom_range(0, 255));
			frame_end_in <= 1'($urandom_range(0, 1));
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		chroma_u     = 8'd0;
		luma_first   = 8'd0;
		chroma_v     = 8'd0;
		luma_second  = 8'd0;
		frame_end_in = 1'b0;
		stream_left  = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Neutral chroma, full extremes, and chroma pushing each channel past either rail.
		send_pair(8'd128, 8'd0, 8'd128, 8'd0, 1'b0, 0);
		send_pair(8'd128, 8'd255, 8'd128, 8'd255, 1'b1, 0);
		send_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1);
		send_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 0);
		send_pair(8'd0, 8'd255, 8'd255, 8'd0, 1'b1, 2);
		send_pair(8'd255, 8'd0, 8'd0, 8'd255, 1'b0, 0);
		send_pair(8'd128, 8'd16, 8'd255, 8'd235, 1'b0, 0);
		send_pair(8'd128, 8'd128, 8'd0, 8'd128, 1'b0, 0);
		send_pair(8'd255, 8'd128, 8'd128, 8'd100, 1'b0, 3);
		send_pair(8'd0, 8'd128, 8'd128, 8'd60, 1'b0, 0);
		send_pair(8'd0, 8'd200, 8'd0, 8'd120, 1'b1, 0);
		send_pair(8'd255, 8'd50, 8'd255, 8'd150, 1'b0, 0);
		send_pair(8'd170, 8'd85, 8'd85, 8'd170, 1'b0, 0);
		send_pair(8'd85, 8'd170, 8'd170, 8'd85, 1'b1, 5);
		send_pair(8'd127, 8'd1, 8'd129, 8'd254, 1'b0, 0);
		send_pair(8'd129, 8'd254, 8'd127, 8'd1, 1'b0, 0);
		send_pair(8'd140, 8'd250, 8'd200, 8'd5, 1'b0, 0);
		send_pair(8'd60, 8'd5, 8'd90, 8'd250, 1'b1, 0);

		repeat (RANDOM_ITEMS) begin
			send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
				1'($urandom_range(0, 15) == 0), pick_gap());
		end

		@(negedge clk);
		start <= 1'b0;
		while (sb.expected_pairs.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fault_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
